FILE: src/rrss_pkg.sv
package rrss_pkg;

  // Default table depth; the top level hands it down as a parameter.
  localparam int MAX_SUBFLOWS_DEFAULT = 8;

  localparam int WIN_W = 32;
  localparam int SEQ_W = 32;
  localparam int LEN_W = 16;
  localparam int IDX_W = 3;
  localparam int ACTIVE_W = 4;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd1;
  localparam logic [LEN_W-1:0] SEGMENT_RESET = 16'd1460;

  // Register select, taken from bit 2 of the byte address.
  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_SEGMENT = 1'b1;

  // Input word kinds, carried on in_tuser.
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic granted;
    logic [IDX_W-1:0] chosen;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
  } result_t;

  typedef struct packed {
    logic idle;
    logic scan;
    logic finish;
  } sched_stat_t;

endpackage

FILE: src/rrss_win_mem.sv
module rrss_win_mem #(
  parameter int DEPTH = rrss_pkg::MAX_SUBFLOWS_DEFAULT,
  parameter int AW = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [rrss_pkg::WIN_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [rrss_pkg::WIN_W-1:0]  rd_data
);

  logic [rrss_pkg::WIN_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [rrss_pkg::WIN_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // An entry never written reads as an empty window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/rrss_sched.sv
module rrss_sched #(
  parameter int MAX_SUBFLOWS = rrss_pkg::MAX_SUBFLOWS_DEFAULT,
  parameter int AW = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [rrss_pkg::IDX_W-1:0]     in_index,
  input  logic [rrss_pkg::WIN_W-1:0]     in_window,
  input  logic [rrss_pkg::SEQ_W-1:0]     in_seq,
  input  logic [rrss_pkg::WIN_W-1:0]     in_pending,
  input  logic [rrss_pkg::WIN_W-1:0]     in_meta,
  input  logic [rrss_pkg::ACTIVE_W-1:0]  active,
  input  logic [rrss_pkg::LEN_W-1:0]     segment,
  output logic                           wr_en,
  output logic [AW-1:0]                  wr_addr,
  output logic [rrss_pkg::WIN_W-1:0]     wr_data,
  output logic                           rd_en,
  output logic [AW-1:0]                  rd_addr,
  input  logic [rrss_pkg::WIN_W-1:0]     rd_data,
  output logic                           res_valid,
  input  logic                           res_ready,
  output rrss_pkg::result_t              res,
  output rrss_pkg::sched_stat_t          stat
);

  localparam int CW = (AW > rrss_pkg::ACTIVE_W) ? AW : rrss_pkg::ACTIVE_W;
  localparam int EW = (AW > rrss_pkg::IDX_W) ? AW : rrss_pkg::IDX_W;
  localparam int LW0 = $clog2(MAX_SUBFLOWS + 1);
  localparam int KW = (LW0 > rrss_pkg::ACTIVE_W) ? LW0 : rrss_pkg::ACTIVE_W;
  localparam int IKW = (LW0 > rrss_pkg::IDX_W) ? LW0 : rrss_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_REDUCE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [rrss_pkg::ACTIVE_W-1:0] cnt_r, cnt_nxt;
  logic [rrss_pkg::SEQ_W-1:0] seq_r, seq_nxt;
  logic [rrss_pkg::WIN_W-1:0] meta_r, meta_nxt;
  logic [rrss_pkg::LEN_W-1:0] cap_r, cap_nxt;
  rrss_pkg::result_t res_r, res_nxt;

  logic [rrss_pkg::ACTIVE_W-1:0] count_n;
  logic [CW-1:0] ptr_ext, n_ext, ptr_inc;
  logic [AW-1:0] ptr_step;
  logic [EW-1:0] ptr_wide;
  logic [IKW-1:0] idx_ext;
  logic idx_ok;

  // Rotation size: zero counts as one, anything above the table as the table.
  always_comb begin
    priority if (active == '0) begin
      count_n = rrss_pkg::ACTIVE_W'(1);
    end else if (KW'(active) > KW'(MAX_SUBFLOWS)) begin
      count_n = rrss_pkg::ACTIVE_W'(MAX_SUBFLOWS);
    end else begin
      count_n = active;
    end
  end

  assign ptr_ext = CW'(ptr_r);
  assign n_ext = CW'(count_n);
  assign ptr_inc = ptr_ext + CW'(1);
  assign ptr_step = (ptr_inc == n_ext) ? '0 : ptr_inc[AW-1:0];
  assign ptr_wide = EW'(ptr_r);

  assign idx_ext = IKW'(in_index);
  assign idx_ok = idx_ext < IKW'(MAX_SUBFLOWS);

  assign in_ready = (state_r == S_IDLE);
  assign wr_en = in_valid && in_ready && (in_kind == rrss_pkg::KIND_UPDATE) && idx_ok;
  assign wr_addr = idx_ext[AW-1:0];
  assign wr_data = in_window;

  always_comb begin
    state_nxt = state_r;
    ptr_nxt = ptr_r;
    cnt_nxt = cnt_r;
    seq_nxt = seq_r;
    meta_nxt = meta_r;
    cap_nxt = cap_r;
    res_nxt = res_r;
    rd_en = 1'b0;
    rd_addr = ptr_step;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && (in_kind == rrss_pkg::KIND_REQUEST)) begin
          seq_nxt = in_seq;
          meta_nxt = in_meta;
          cnt_nxt = count_n;
          cap_nxt = (in_pending < rrss_pkg::WIN_W'(segment)) ?
                    in_pending[rrss_pkg::LEN_W-1:0] : segment;
          if ((in_pending == '0) || (in_meta == '0)) begin
            res_nxt = '0;
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        // Fold the connection window into the length cap.
        if (meta_r < rrss_pkg::WIN_W'(cap_r)) begin
          cap_nxt = meta_r[rrss_pkg::LEN_W-1:0];
        end
        // Bring the pointer below the rotation size, then take the first step.
        if (ptr_ext >= n_ext) begin
          ptr_nxt = AW'(ptr_ext - n_ext);
        end else begin
          ptr_nxt = ptr_step;
          rd_en = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_data != '0) begin
          res_nxt.granted = 1'b1;
          res_nxt.chosen = ptr_wide[rrss_pkg::IDX_W-1:0];
          res_nxt.seq = seq_r;
          res_nxt.len = (rd_data < rrss_pkg::WIN_W'(cap_r)) ?
                        rd_data[rrss_pkg::LEN_W-1:0] : cap_r;
          state_nxt = S_FINISH;
        end else if (cnt_r == rrss_pkg::ACTIVE_W'(1)) begin
          res_nxt = '0;
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt = cnt_r - rrss_pkg::ACTIVE_W'(1);
          ptr_nxt = ptr_step;
          rd_en = 1'b1;
        end
      end
      S_FINISH: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r <= ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    meta_r <= meta_nxt;
    cap_r <= cap_nxt;
    res_r <= res_nxt;
  end

  assign res_valid = (state_r == S_FINISH);
  assign res = res_r;
  assign stat.idle = (state_r == S_IDLE);
  assign stat.scan = (state_r == S_SCAN);
  assign stat.finish = (state_r == S_FINISH);

endmodule

FILE: src/round_robin_subflow_scheduler.sv
// Round-robin subflow scheduler. The block holds one free send window per
// subflow in a small table memory and a pointer to the subflow used last.
// A window update word (in_tuser low) writes one table entry and gives no
// result. A mapping request word (in_tuser high) gives exactly one result
// word: when the pending byte count or the connection window is zero it
// answers at once with an all-zero, not-granted word. Otherwise it tries
// the active subflows one per cycle, starting after the last used one and
// wrapping, and grants the first one with a nonzero window; the length is
// the smallest of that window, the connection window, the pending bytes and
// the segment size. The pointer moves on each subflow tried, so a search
// that finds nothing leaves it at its starting value taken modulo the active
// count. After the active count has been lowered below the pointer, the
// first request that searches subtracts the count from the pointer until it
// is below it before the search starts. A finished result sits in an output
// register, so the next word is taken while it waits. Configuration is to be
// written by the user only while the block is idle; the block itself does
// not enforce this.
module round_robin_subflow_scheduler #(
  parameter int MAX_SUBFLOWS = rrss_pkg::MAX_SUBFLOWS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  // Input stream.
  input  logic          in_tvalid,
  output logic          in_tready,
  // tdata, from bit 0: subflow_index[2:0], subflow_window[34:3],
  // next_seq[66:35], pending_bytes[98:67], meta_window[130:99], zero pad.
  input  logic [135:0]  in_tdata,
  // tuser: kind (0 = window update, 1 = mapping request).
  input  logic          in_tuser,
  // Result stream.
  output logic          out_tvalid,
  input  logic          out_tready,
  // tdata, from bit 0: chosen_subflow[2:0], data_seq[34:3],
  // map_length[50:35], zero pad.
  output logic [55:0]   out_tdata,
  // tuser: granted.
  output logic          out_tuser,
  // Configuration port.
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  localparam int AW = (MAX_SUBFLOWS > 1) ? $clog2(MAX_SUBFLOWS) : 1;

  // Configuration registers.
  logic [rrss_pkg::ACTIVE_W-1:0] active_r, active_nxt;
  logic [rrss_pkg::LEN_W-1:0] segment_r, segment_nxt;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    active_nxt = active_r;
    segment_nxt = segment_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        rrss_pkg::REG_ACTIVE:  active_nxt = cfg_pwdata[rrss_pkg::ACTIVE_W-1:0];
        rrss_pkg::REG_SEGMENT: segment_nxt = cfg_pwdata[rrss_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      rrss_pkg::REG_ACTIVE:  cfg_prdata = 32'(active_r);
      rrss_pkg::REG_SEGMENT: cfg_prdata = 32'(segment_r);
      default:               cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= rrss_pkg::ACTIVE_RESET;
      segment_r <= rrss_pkg::SEGMENT_RESET;
    end else begin
      active_r <= active_nxt;
      segment_r <= segment_nxt;
    end
  end

  // Scheduler and window table.
  logic wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [rrss_pkg::WIN_W-1:0] wr_data, rd_data;
  logic res_valid, res_ready;
  rrss_pkg::result_t res;
  rrss_pkg::sched_stat_t stat;

  rrss_win_mem #(
    .DEPTH (MAX_SUBFLOWS),
    .AW    (AW)
  ) u_win_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rrss_sched #(
    .MAX_SUBFLOWS (MAX_SUBFLOWS),
    .AW           (AW)
  ) u_sched (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_index   (in_tdata[2:0]),
    .in_window  (in_tdata[34:3]),
    .in_seq     (in_tdata[66:35]),
    .in_pending (in_tdata[98:67]),
    .in_meta    (in_tdata[130:99]),
    .active     (active_r),
    .segment    (segment_r),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .stat       (stat)
  );

  // Output register: the scheduler hands over a result whenever the slot is
  // empty or being emptied in this cycle.
  logic out_valid_r, out_valid_nxt;
  rrss_pkg::result_t out_res_r, out_res_nxt;

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = out_res_r.granted;
  assign out_tdata = {5'b0, out_res_r.len, out_res_r.seq, out_res_r.chosen};

  // A result that grants nothing carries no subflow, sequence or length.
  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("not-granted result carries nonzero fields");

  // A request with nothing to send skips the search and answers next cycle.
  a_trivial_finish: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == rrss_pkg::KIND_REQUEST) &&
    ((in_tdata[98:67] == '0) || (in_tdata[130:99] == '0)) |=> stat.finish)
    else $error("trivial request did not finish at once");

  // The table is never written while a search is reading it.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    stat.scan |-> !wr_en)
    else $error("window write during search");

  // A new result is only handed over when the output slot can take it.
  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_tvalid && !stat.finish)
    else $error("result handover lost");

endmodule

FILE: verif/tb_round_robin_subflow_scheduler.sv
`timescale 1ns / 1ps

module tb_round_robin_subflow_scheduler;

  // Run shape. The idle rate applies per cycle on both sides; one random phase
  // runs with no idling at all.
  localparam int IDLE_PCT = 35;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int CALM_PHASE = 4;
  // The settle wait covers the longest request, including the extra pointer
  // steps after the active count drops below the pointer.
  localparam int SETTLE_CYCLES = 40;
  // The receiver stops once for a long stretch after this many results.
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 500000;
  localparam int NSUB = rrss_pkg::MAX_SUBFLOWS_DEFAULT;
  localparam int IDX_W = rrss_pkg::IDX_W;
  localparam int WIN_W = rrss_pkg::WIN_W;
  localparam int SEQ_W = rrss_pkg::SEQ_W;
  localparam int LEN_W = rrss_pkg::LEN_W;
  localparam int ACTIVE_W = rrss_pkg::ACTIVE_W;

  typedef enum logic [1:0] {
    ROW_UPDATE,
    ROW_REQUEST,
    ROW_CFG
  } row_kind_e;

  // One line of stimulus. A configuration line uses cfg_sel and cfg_val; a
  // line with a typed result carries it in want and has typed set.
  typedef struct packed {
    row_kind_e what;
    logic [IDX_W-1:0] idx;
    logic [WIN_W-1:0] win;
    logic [SEQ_W-1:0] seq;
    logic [31:0] pend;
    logic [WIN_W-1:0] meta;
    logic cfg_sel;
    logic [31:0] cfg_val;
    logic typed;
    rrss_pkg::result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [135:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [55:0] out_tdata;
  logic out_tuser;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  round_robin_subflow_scheduler u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Scheduler state as the testbench sees it: the window table, the pointer
  // to the subflow used last, and the two registers.
  logic [WIN_W-1:0] win_tab [NSUB];
  int rr_last;
  logic [ACTIVE_W-1:0] act_reg;
  logic [LEN_W-1:0] seg_reg;

  // Mappings still owed by the block, oldest first.
  rrss_pkg::result_t mapping_q [$];
  int fault_cnt;
  int got_count;
  int cycle_cnt;
  bit calm;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the mapping for one request and moves the pointer the way the
  // block does: one step per subflow tried.
  function automatic rrss_pkg::result_t predict_mapping(logic [SEQ_W-1:0] seq,
                                                        logic [31:0] pend,
                                                        logic [WIN_W-1:0] meta);
    rrss_pkg::result_t r;
    int n;
    logic [31:0] room;
    r = '0;
    // With nothing to send or no connection window the pointer stays put.
    if (pend == 0 || meta == 0) return r;
    // Out-of-range active counts are clamped to the table.
    n = int'(act_reg);
    if (n == 0) n = 1;
    if (n > NSUB) n = NSUB;
    for (int t = 0; t < n; t++) begin
      rr_last = (rr_last % n + 1) % n;
      room = (win_tab[rr_last] < meta) ? win_tab[rr_last] : meta;
      if (room != 0) begin
        if (pend < room) room = pend;
        if ({16'h0, seg_reg} < room) room = {16'h0, seg_reg};
        r.granted = 1'b1;
        r.chosen = rr_last[IDX_W-1:0];
        r.seq = seq;
        r.len = room[LEN_W-1:0];
        return r;
      end
    end
    // Nobody had room: a full lap leaves the pointer at its start modulo n.
    return r;
  endfunction

  function automatic stim_row_t row_upd(logic [IDX_W-1:0] idx, logic [WIN_W-1:0] win);
    stim_row_t r;
    r = '0;
    r.what = ROW_UPDATE;
    r.idx = idx;
    r.win = win;
    return r;
  endfunction

  function automatic stim_row_t row_req(logic [SEQ_W-1:0] seq, logic [31:0] pend,
                                        logic [WIN_W-1:0] meta);
    stim_row_t r;
    r = '0;
    r.what = ROW_REQUEST;
    r.seq = seq;
    r.pend = pend;
    r.meta = meta;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(logic sel, logic [31:0] val);
    stim_row_t r;
    r = '0;
    r.what = ROW_CFG;
    r.cfg_sel = sel;
    r.cfg_val = val;
    return r;
  endfunction

  // Attaches a result typed in by hand to a request line.
  function automatic stim_row_t with_want(stim_row_t row, logic g, logic [IDX_W-1:0] ch,
                                          logic [SEQ_W-1:0] sq, logic [LEN_W-1:0] ln);
    stim_row_t r;
    r = row;
    r.typed = 1'b1;
    r.want.granted = g;
    r.want.chosen = ch;
    r.want.seq = sq;
    r.want.len = ln;
    return r;
  endfunction

  // Byte counts lean on zero, small values and the top of the range, so that
  // searches wrap and every term of the minimum gets its turn.
  function automatic logic [31:0] pick_bytes(int zero_pct);
    int r;
    r = $urandom_range(99);
    if (r < zero_pct) return 32'h0;
    if (r < zero_pct + 25) return 32'($urandom_range(1, 4000));
    if (r < zero_pct + 35) return 32'hFFFF_FFFF;
    return 32'($urandom);
  endfunction

  // Random words carry noise in the fields their kind does not use.
  function automatic stim_row_t random_row();
    stim_row_t r;
    r = '0;
    r.what = ($urandom_range(99) < 30) ? ROW_UPDATE : ROW_REQUEST;
    r.idx = IDX_W'($urandom_range(NSUB - 1));
    r.win = (r.what == ROW_UPDATE) ? pick_bytes(45) : WIN_W'($urandom);
    r.seq = SEQ_W'($urandom);
    r.pend = pick_bytes(6);
    r.meta = pick_bytes(6);
    return r;
  endfunction

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(logic sel, logic [31:0] val);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {sel, 2'b00};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (sel == rrss_pkg::REG_ACTIVE) act_reg = val[ACTIVE_W-1:0];
    else seg_reg = val[LEN_W-1:0];
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // Offers one word and applies it to the model state once it is taken.
  // Returns at a falling edge with tvalid still high, so back-to-back words
  // keep valid high unless the sender idles between them.
  task automatic send_word(stim_row_t row);
    rrss_pkg::result_t r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser = (row.what == ROW_REQUEST) ? rrss_pkg::KIND_REQUEST : rrss_pkg::KIND_UPDATE;
    in_tdata = {5'b0, row.meta, row.pend, row.seq, row.win, row.idx};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    if (row.what == ROW_UPDATE) begin
      win_tab[row.idx] = row.win;
    end else begin
      r = predict_mapping(row.seq, row.pend, row.meta);
      mapping_q.push_back(row.typed ? row.want : r);
    end
    @(negedge clk);
  endtask

  // Waits until every owed mapping is out, then lets the block settle, since
  // a window update leaves no trace on the output.
  task automatic drain();
    in_tvalid = 1'b0;
    while (mapping_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_row(stim_row_t row);
    if (row.what == ROW_CFG) begin
      drain();
      write_reg(row.cfg_sel, row.cfg_val);
    end else begin
      send_word(row);
    end
  endtask

  // Receiver: random backpressure, one long hold-off while the sender keeps
  // pushing, and no stalls at all during the calm phase.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (!held && got_count >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Result checker: every accepted word is compared with the oldest mapping
  // owed.
  always @(posedge clk) begin
    rrss_pkg::result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got_count++;
      if (mapping_q.size() == 0) begin
        $error("result word with no request waiting: granted %0d subflow %0d",
               out_tuser, out_tdata[2:0]);
        fault_cnt++;
      end else begin
        exp_r = mapping_q.pop_front();
        if (out_tuser !== exp_r.granted) begin
          $error("granted: expected %0d, got %0d", exp_r.granted, out_tuser);
          fault_cnt++;
        end
        if (out_tdata[2:0] !== exp_r.chosen) begin
          $error("chosen_subflow: expected %0d, got %0d", exp_r.chosen, out_tdata[2:0]);
          fault_cnt++;
        end
        if (out_tdata[34:3] !== exp_r.seq) begin
          $error("data_seq: expected %h, got %h", exp_r.seq, out_tdata[34:3]);
          fault_cnt++;
        end
        if (out_tdata[50:35] !== exp_r.len) begin
          $error("map_length: expected %0d, got %0d", exp_r.len, out_tdata[50:35]);
          fault_cnt++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_rows [$];
    logic [31:0] act_val;
    logic [31:0] seg_val;

    fault_cnt = 0;
    got_count = 0;
    cycle_cnt = 0;
    calm = 1'b0;
    rr_last = 0;
    act_reg = rrss_pkg::ACTIVE_RESET;
    seg_reg = rrss_pkg::SEGMENT_RESET;
    foreach (win_tab[i]) win_tab[i] = '0;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = rrss_pkg::KIND_UPDATE;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. It starts from the reset registers: one active subflow,
    // 1460-byte segments, and an empty window table. The trace walks the
    // pointer to subflow 7 with eight active and full-range segments, then
    // drops the count to two so the pointer sits beyond it. Zero and oversized
    // active counts, a zero segment size, and a full lap with no window follow.
    dir_rows = '{
      with_want(row_req(32'hFFFF_FFFF, 32'd0, 32'd5), 1'b0, 3'd0, 32'd0, 16'd0),
      with_want(row_req(32'hFFFF_FFFF, 32'd5, 32'd0), 1'b0, 3'd0, 32'd0, 16'd0),
      with_want(row_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                1'b0, 3'd0, 32'd0, 16'd0),
      row_upd(3'd0, 32'hFFFF_FFFF),
      with_want(row_req(32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                1'b1, 3'd0, 32'h1234_5678, 16'd1460),
      row_upd(3'd7, 32'd1),
      row_upd(3'd5, 32'h8000_0000),
      row_upd(3'd3, 32'd100),
      row_cfg(rrss_pkg::REG_ACTIVE, 32'd8),
      row_cfg(rrss_pkg::REG_SEGMENT, 32'd65535),
      row_req(32'd0, 32'hFFFF_FFFF, 32'd50),
      row_req(32'hA5A5_A5A5, 32'd7, 32'hFFFF_FFFF),
      row_req(32'h5A5A_5A5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      row_cfg(rrss_pkg::REG_ACTIVE, 32'd2),
      row_req(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      row_cfg(rrss_pkg::REG_SEGMENT, 32'd0),
      row_req(32'h8000_0000, 32'd300, 32'd200),
      row_cfg(rrss_pkg::REG_ACTIVE, 32'd0),
      row_req(32'h7FFF_FFFF, 32'd1, 32'd1),
      row_cfg(rrss_pkg::REG_ACTIVE, 32'd15),
      row_cfg(rrss_pkg::REG_SEGMENT, 32'd1),
      row_req(32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      row_upd(3'd3, 32'd0),
      row_upd(3'd0, 32'd0),
      row_upd(3'd5, 32'd0),
      row_upd(3'd7, 32'd0),
      with_want(row_req(32'hCAFE_F00D, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                1'b0, 3'd0, 32'd0, 16'd0)
    };
    foreach (dir_rows[i]) run_row(dir_rows[i]);

    // Random part. Each phase waits for the block to empty, which also makes
    // the sender pause until every mapping is back, then sets new registers.
    // The first three phases pin the register extremes.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          act_val = 32'd8;
          seg_val = 32'd65535;
        end
        1: begin
          act_val = 32'd0;
          seg_val = 32'd0;
        end
        2: begin
          act_val = 32'd15;
          seg_val = 32'd1;
        end
        default: begin
          act_val = 32'($urandom_range(15));
          seg_val = ($urandom_range(1) == 0) ? 32'($urandom_range(1, 64))
                                             : 32'($urandom_range(1, 65535));
        end
      endcase
      drain();
      write_reg(rrss_pkg::REG_ACTIVE, act_val);
      write_reg(rrss_pkg::REG_SEGMENT, seg_val);
      calm = (ph == CALM_PHASE);
      for (int k = 0; k < PHASE_ITEMS; k++) send_word(random_row());
    end

    calm = 1'b0;
    drain();
    if (fault_cnt == 0 && mapping_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
